// File: design/hrp_pkg.sv
// Package for the hex record parser: beat types, parse phases, status codes
// and the hex digit decoder. No dependencies.
package hrp_pkg;

  // Input beat: one character or an end-of-input mark.
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_t;

  // Result beat: a data byte or a record status.
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  byte_count;
    logic [15:0] load_address;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
  } out_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_COMMENT = 4'd1,
    PH_COUNT   = 4'd2,
    PH_ADDRH   = 4'd3,
    PH_ADDRL   = 4'd4,
    PH_TYPE    = 4'd5,
    PH_DATA    = 4'd6,
    PH_CKSUM   = 4'd7,
    PH_CR      = 4'd8,
    PH_LF      = 4'd9,
    PH_EOFLINE = 4'd10
  } phase_t;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EOF       = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
  localparam logic [2:0] ST_CHECKSUM  = 3'd4;
  localparam logic [2:0] ST_ENDED     = 3'd5;

  // Characters of interest.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Decoder codes beyond the sixteen digit values.
  localparam logic [4:0] DIG_EOF = 5'd16;
  localparam logic [4:0] DIG_BAD = 5'd17;

  // Maps an upper-case hex character to 0..15, the end-of-file mark to
  // DIG_EOF and anything else to DIG_BAD.
  function automatic logic [4:0] decode_digit(input logic [7:0] ch);
    logic [7:0] diff;
    diff = 8'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      diff = ch - CH_ZERO;
      return diff[4:0];
    end else if (ch >= CH_A && ch <= CH_F) begin
      diff = ch - CH_A + 8'd10;
      return diff[4:0];
    end else if (ch == CH_SUB) begin
      return DIG_EOF;
    end
    return DIG_BAD;
  endfunction

endpackage

// File: design/hrp_in_stage.sv
// Input register of the hex record parser: holds one character beat.
// Depends on hrp_pkg for the beat type.
module hrp_in_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  hrp_pkg::in_t in_data,
  input  logic         advance,
  output logic         item_valid,
  output hrp_pkg::in_t item
);

  logic         vld_r;
  hrp_pkg::in_t data_r;

  // The register takes a new beat when it is empty or its beat moves on.
  assign in_ready   = !vld_r || advance;
  assign item_valid = vld_r && advance;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule

// File: design/hrp_step.sv
// Parser state machine of the hex record parser: handles one character per
// cycle when item_valid is high and forms at most one result. Depends on hrp_pkg.
module hrp_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  hrp_pkg::in_t  item,
  output logic          res_valid,
  output hrp_pkg::out_t res
);

  hrp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      high_nibble_r, high_nibble_nxt;
  logic            second_digit_r, second_digit_nxt;
  logic [7:0]      record_length_r, record_length_nxt;
  logic [15:0]     address_r, address_nxt;
  logic [7:0]      running_sum_r, running_sum_nxt;
  logic [7:0]      bytes_seen_r, bytes_seen_nxt;

  logic [7:0] ch;
  logic       ended;
  logic [4:0] dig;
  logic [7:0] value;
  logic [7:0] seen_inc;
  logic [7:0] sum_want;
  logic       emit;
  logic [2:0] emit_code;

  assign ch         = item.char_in;
  assign ended      = item.end_of_input;
  assign dig        = hrp_pkg::decode_digit(ch);
  assign value      = {high_nibble_r, dig[3:0]};
  assign seen_inc   = bytes_seen_r + 8'd1;
  assign sum_want   = 8'd0 - running_sum_r;

  // State registers advance only when a character is handled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= hrp_pkg::PH_IDLE;
      high_nibble_r   <= 4'd0;
      second_digit_r  <= 1'b0;
      record_length_r <= 8'd0;
      address_r       <= 16'd0;
      running_sum_r   <= 8'd0;
      bytes_seen_r    <= 8'd0;
    end else if (item_valid) begin
      phase_r         <= phase_nxt;
      high_nibble_r   <= high_nibble_nxt;
      second_digit_r  <= second_digit_nxt;
      record_length_r <= record_length_nxt;
      address_r       <= address_nxt;
      running_sum_r   <= running_sum_nxt;
      bytes_seen_r    <= bytes_seen_nxt;
    end
  end

  // Next state and result for the current character.
  always_comb begin
    phase_nxt         = phase_r;
    high_nibble_nxt   = high_nibble_r;
    second_digit_nxt  = second_digit_r;
    record_length_nxt = record_length_r;
    address_nxt       = address_r;
    running_sum_nxt   = running_sum_r;
    bytes_seen_nxt    = bytes_seen_r;
    emit              = 1'b0;
    emit_code         = hrp_pkg::ST_OK;
    res_valid         = 1'b0;
    res.kind          = hrp_pkg::KIND_DATA;
    res.status        = hrp_pkg::ST_OK;
    res.byte_count    = record_length_r;
    res.load_address  = address_r;
    res.byte_index    = 8'd0;
    res.data_byte     = 8'd0;

    unique case (phase_r)
      hrp_pkg::PH_IDLE: begin
        if (ended) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_BAD_START;
        end else if (ch == hrp_pkg::CH_COLON || ch == hrp_pkg::CH_SEMI) begin
          record_length_nxt = 8'd0;
          address_nxt       = 16'd0;
          running_sum_nxt   = 8'd0;
          bytes_seen_nxt    = 8'd0;
          second_digit_nxt  = 1'b0;
          phase_nxt = (ch == hrp_pkg::CH_COLON) ? hrp_pkg::PH_COUNT : hrp_pkg::PH_COMMENT;
        end else begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_BAD_START;
        end
      end
      hrp_pkg::PH_COMMENT: begin
        if (ended) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_ENDED;
        end else if (ch == hrp_pkg::CH_COLON) begin
          phase_nxt = hrp_pkg::PH_COUNT;
        end
      end
      hrp_pkg::PH_EOFLINE: begin
        if (ended) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_ENDED;
        end else if (ch == hrp_pkg::CH_LF) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_EOF;
        end else if (ch != hrp_pkg::CH_ZERO && ch != hrp_pkg::CH_CR) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_BAD_START;
        end
      end
      hrp_pkg::PH_CR: begin
        if (ended || ch != hrp_pkg::CH_CR) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_BAD_DIGIT;
        end else begin
          phase_nxt = hrp_pkg::PH_LF;
        end
      end
      hrp_pkg::PH_LF: begin
        emit = 1'b1;
        if (ended || ch != hrp_pkg::CH_LF) begin
          emit_code = hrp_pkg::ST_BAD_DIGIT;
        end else begin
          emit_code = hrp_pkg::ST_OK;
        end
      end
      hrp_pkg::PH_COUNT, hrp_pkg::PH_ADDRH, hrp_pkg::PH_ADDRL,
      hrp_pkg::PH_TYPE, hrp_pkg::PH_DATA, hrp_pkg::PH_CKSUM: begin
        // Hex pair: the first digit is held, the second completes a byte.
        if (ended) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_ENDED;
        end else if (dig == hrp_pkg::DIG_EOF) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_EOF;
        end else if (dig == hrp_pkg::DIG_BAD) begin
          emit      = 1'b1;
          emit_code = hrp_pkg::ST_BAD_DIGIT;
        end else if (!second_digit_r) begin
          high_nibble_nxt  = dig[3:0];
          second_digit_nxt = 1'b1;
        end else begin
          second_digit_nxt = 1'b0;
          priority case (phase_r)
            hrp_pkg::PH_COUNT: begin
              if (value == 8'd0) begin
                phase_nxt = hrp_pkg::PH_EOFLINE;
              end else begin
                record_length_nxt = value;
                running_sum_nxt   = value;
                phase_nxt         = hrp_pkg::PH_ADDRH;
              end
            end
            hrp_pkg::PH_ADDRH: begin
              address_nxt     = {value, 8'd0};
              running_sum_nxt = running_sum_r + value;
              phase_nxt       = hrp_pkg::PH_ADDRL;
            end
            hrp_pkg::PH_ADDRL: begin
              address_nxt     = {address_r[15:8], value};
              running_sum_nxt = running_sum_r + value;
              phase_nxt       = hrp_pkg::PH_TYPE;
            end
            hrp_pkg::PH_TYPE: begin
              bytes_seen_nxt = 8'd0;
              phase_nxt      = hrp_pkg::PH_DATA;
            end
            hrp_pkg::PH_DATA: begin
              res_valid       = 1'b1;
              res.byte_index  = bytes_seen_r;
              res.data_byte   = value;
              running_sum_nxt = running_sum_r + value;
              bytes_seen_nxt  = seen_inc;
              if (seen_inc >= record_length_r) begin
                phase_nxt = hrp_pkg::PH_CKSUM;
              end
            end
            default: begin
              // Checksum byte: must equal the negated running sum.
              if (sum_want != value) begin
                emit      = 1'b1;
                emit_code = hrp_pkg::ST_CHECKSUM;
              end else begin
                phase_nxt = hrp_pkg::PH_CR;
              end
            end
          endcase
        end
      end
      default: begin
        phase_nxt = hrp_pkg::PH_IDLE;
      end
    endcase

    // Any status ends the record and returns to idle.
    if (emit) begin
      res_valid        = 1'b1;
      res.kind         = hrp_pkg::KIND_STATUS;
      res.status       = emit_code;
      res.byte_index   = 8'd0;
      res.data_byte    = 8'd0;
      phase_nxt        = hrp_pkg::PH_IDLE;
      second_digit_nxt = 1'b0;
      high_nibble_nxt  = 4'd0;
    end

    res_valid = res_valid && item_valid;
  end

endmodule

// File: design/hrp_out_stage.sv
// Result register of the hex record parser: holds one result beat until
// taken. Depends on hrp_pkg for the beat type.
module hrp_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  hrp_pkg::out_t res,
  output logic          advance,
  output logic          out_valid,
  input  logic          out_ready,
  output hrp_pkg::out_t out_data
);

  logic          vld_r;
  hrp_pkg::out_t data_r;

  // The pipeline moves whenever the result register is free or drained.
  assign advance   = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      data_r <= res;
    end
  end

endmodule

// File: design/hex_record_parser.sv
// Top level of the hex record parser: input register, parser state machine
// and result register. Depends on hrp_pkg and the hrp_* modules.
//
// Parses Intel HEX text one character beat per cycle unless the result
// register is held: with out_ready held high a new beat is accepted on
// every clock. A beat's result, if any, passes on its way to the output
// through the input register, where the beat waits, and the result
// register, which captures its result; the parser state machine between
// them decides each character combinationally. Data bytes come out as they
// complete, followed by one status beat per record.
module hex_record_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hrp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hrp_pkg::out_t out_data
);

  logic          advance;
  logic          item_valid;
  hrp_pkg::in_t  item;
  logic          res_valid;
  hrp_pkg::out_t res;

  hrp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hrp_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .res_valid  (res_valid),
    .res        (res)
  );

  hrp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/hex_record_parser_test.sv
// Self-checking testbench for hex_record_parser: a directed table of records and
// error cases, then random HEX text, checked against the table's typed results and
// an in-house parse model. Depends on hrp_pkg and the hex_record_parser RTL.
`timescale 1ns / 1ps

module hex_record_parser_test;

  localparam int unsigned RANDOM_BEATS = 1650;
  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RESET_CYCLES = 7;

  // Characters the package does not name.
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  hrp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  hrp_pkg::out_t out_data;

  // Idle rates in percent, and the receiver's long hold-off in cycles.
  int unsigned tx_idle_pct = 24;
  int unsigned rx_idle_pct = 69;
  int unsigned hold_left   = 0;

  int unsigned cycle_count = 0;
  int unsigned n_errors    = 0;
  int unsigned text_beats  = 0;
  int unsigned colon_at    = 0;

  // Results the parse model has produced and the block still owes.
  hrp_pkg::out_t parsed_results[$];
  // HEX text waiting to be sent.
  hrp_pkg::in_t  hex_text[$];

  // Directed table: character beat, whether the result is typed in, and that result.
  hrp_pkg::in_t  row_beat[$];
  bit            row_typed[$];
  hrp_pkg::out_t row_want[$];

  // Parse model state.
  hrp_pkg::phase_t pr_phase  = hrp_pkg::PH_IDLE;
  logic [3:0]      pr_nibble = '0;
  logic            pr_second = 1'b0;
  logic [7:0]      pr_len    = '0;
  logic [15:0]     pr_addr   = '0;
  logic [7:0]      pr_sum    = '0;
  logic [7:0]      pr_seen   = '0;

  hex_record_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic hrp_pkg::in_t mk_beat(input logic [7:0] c, input logic eoi);
    hrp_pkg::in_t b;
    b.char_in      = c;
    b.end_of_input = eoi;
    return b;
  endfunction

  function automatic hrp_pkg::out_t status_beat(input logic [2:0] st, input logic [7:0] cnt,
                                                input logic [15:0] addr);
    hrp_pkg::out_t r;
    r              = '0;
    r.kind         = hrp_pkg::KIND_STATUS;
    r.status       = st;
    r.byte_count   = cnt;
    r.load_address = addr;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return hrp_pkg::CH_ZERO + {4'd0, n};
    end
    return hrp_pkg::CH_A + {4'd0, n} - 8'd10;
  endfunction

  function automatic void add_row(input logic [7:0] c, input logic eoi, input bit typed,
                                  input hrp_pkg::out_t want);
    row_beat.push_back(mk_beat(c, eoi));
    row_typed.push_back(typed);
    row_want.push_back(want);
  endfunction

  // Counted text beats; comment bodies go straight into hex_text.
  function automatic void queue_beat(input logic [7:0] c, input logic eoi);
    hex_text.push_back(mk_beat(c, eoi));
    text_beats++;
  endfunction

  function automatic void queue_byte(input logic [7:0] v);
    queue_beat(hex_char(v[7:4]), 1'b0);
    queue_beat(hex_char(v[3:0]), 1'b0);
  endfunction

  function automatic void note_error(input string what, input hrp_pkg::out_t want,
                                     input hrp_pkg::out_t got);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("%0t %s: want kind=%0d status=%0d count=%h addr=%h index=%h data=%h",
               $time, what, want.kind, want.status, want.byte_count, want.load_address,
               want.byte_index, want.data_byte);
      $display("          got  kind=%0d status=%0d count=%h addr=%h index=%h data=%h",
               got.kind, got.status, got.byte_count, got.load_address, got.byte_index,
               got.data_byte);
    end
  endfunction

  // Parse model: advances the state by one beat and returns the result, if any.
  task automatic parse_char(input hrp_pkg::in_t b, output bit has,
                            output hrp_pkg::out_t res);
    logic [7:0] c;
    logic [3:0] nib;
    logic [7:0] val;
    logic [7:0] want_sum;
    logic       is_hex;
    bit         fin;
    logic [2:0] st;
    c        = b.char_in;
    has      = 1'b0;
    res      = '0;
    fin      = 1'b0;
    st       = hrp_pkg::ST_OK;
    val      = '0;
    want_sum = '0;
    // Digit value: '0'..'9' carry it in the low nibble, 'A'..'F' need nine more.
    is_hex = 1'b1;
    if (c >= hrp_pkg::CH_ZERO && c <= hrp_pkg::CH_NINE) begin
      nib = c[3:0];
    end else if (c >= hrp_pkg::CH_A && c <= hrp_pkg::CH_F) begin
      nib = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
      nib    = '0;
    end

    case (pr_phase)
      hrp_pkg::PH_IDLE: begin
        if (b.end_of_input || (c != hrp_pkg::CH_COLON && c != hrp_pkg::CH_SEMI)) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_BAD_START;
        end else begin
          pr_len    = '0;
          pr_addr   = '0;
          pr_sum    = '0;
          pr_seen   = '0;
          pr_second = 1'b0;
          pr_phase  = (c == hrp_pkg::CH_COLON) ? hrp_pkg::PH_COUNT : hrp_pkg::PH_COMMENT;
        end
      end
      hrp_pkg::PH_COMMENT: begin
        if (b.end_of_input) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_ENDED;
        end else if (c == hrp_pkg::CH_COLON) begin
          pr_phase = hrp_pkg::PH_COUNT;
        end
      end
      hrp_pkg::PH_EOFLINE: begin
        if (b.end_of_input) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_ENDED;
        end else if (c == hrp_pkg::CH_LF) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_EOF;
        end else if (c != hrp_pkg::CH_ZERO && c != hrp_pkg::CH_CR) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_BAD_START;
        end
      end
      hrp_pkg::PH_CR: begin
        if (b.end_of_input || c != hrp_pkg::CH_CR) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_BAD_DIGIT;
        end else begin
          pr_phase = hrp_pkg::PH_LF;
        end
      end
      hrp_pkg::PH_LF: begin
        fin = 1'b1;
        st  = (b.end_of_input || c != hrp_pkg::CH_LF) ? hrp_pkg::ST_BAD_DIGIT : hrp_pkg::ST_OK;
      end
      hrp_pkg::PH_COUNT, hrp_pkg::PH_ADDRH, hrp_pkg::PH_ADDRL, hrp_pkg::PH_TYPE,
      hrp_pkg::PH_DATA, hrp_pkg::PH_CKSUM: begin
        if (b.end_of_input) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_ENDED;
        end else if (c == hrp_pkg::CH_SUB) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_EOF;
        end else if (!is_hex) begin
          fin = 1'b1;
          st  = hrp_pkg::ST_BAD_DIGIT;
        end else if (!pr_second) begin
          pr_nibble = nib;
          pr_second = 1'b1;
        end else begin
          // Second digit completes a byte; what it means depends on the field.
          pr_second = 1'b0;
          val       = {pr_nibble, nib};
          case (pr_phase)
            hrp_pkg::PH_COUNT: begin
              if (val == 8'd0) begin
                pr_phase = hrp_pkg::PH_EOFLINE;
              end else begin
                pr_len   = val;
                pr_sum   = val;
                pr_phase = hrp_pkg::PH_ADDRH;
              end
            end
            hrp_pkg::PH_ADDRH: begin
              pr_addr  = {val, 8'd0};
              pr_sum   = pr_sum + val;
              pr_phase = hrp_pkg::PH_ADDRL;
            end
            hrp_pkg::PH_ADDRL: begin
              pr_addr[7:0] = val;
              pr_sum       = pr_sum + val;
              pr_phase     = hrp_pkg::PH_TYPE;
            end
            hrp_pkg::PH_TYPE: begin
              pr_seen  = '0;
              pr_phase = hrp_pkg::PH_DATA;
            end
            hrp_pkg::PH_DATA: begin
              has              = 1'b1;
              res.kind         = hrp_pkg::KIND_DATA;
              res.status       = hrp_pkg::ST_OK;
              res.byte_count   = pr_len;
              res.load_address = pr_addr;
              res.byte_index   = pr_seen;
              res.data_byte    = val;
              pr_sum           = pr_sum + val;
              pr_seen          = pr_seen + 8'd1;
              if (pr_seen >= pr_len) begin
                pr_phase = hrp_pkg::PH_CKSUM;
              end
            end
            default: begin
              want_sum = ~pr_sum + 8'd1;
              if (val != want_sum) begin
                fin = 1'b1;
                st  = hrp_pkg::ST_CHECKSUM;
              end else begin
                pr_phase = hrp_pkg::PH_CR;
              end
            end
          endcase
        end
      end
      default: begin
        pr_phase = hrp_pkg::PH_IDLE;
      end
    endcase

    // Any status ends the record and returns the parser to idle.
    if (fin) begin
      has       = 1'b1;
      res       = status_beat(st, pr_len, pr_addr);
      pr_phase  = hrp_pkg::PH_IDLE;
      pr_second = 1'b0;
      pr_nibble = '0;
    end
  endtask

  // Offers one beat, with random idle cycles ahead of it, and books its result.
  task automatic send_beat(input hrp_pkg::in_t b, input bit typed,
                           input hrp_pkg::out_t want);
    bit            has;
    hrp_pkg::out_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    parse_char(b, has, res);
    if (typed) begin
      parsed_results.push_back(want);
    end else if (has) begin
      parsed_results.push_back(res);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off counted here.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Result checker: every accepted beat against the oldest booked result.
  always @(posedge clk) begin
    hrp_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (parsed_results.size() == 0) begin
        note_error("result with nothing pending", '0, out_data);
      end else begin
        want = parsed_results.pop_front();
        if (out_data.kind !== want.kind || out_data.status !== want.status ||
            out_data.byte_count !== want.byte_count ||
            out_data.load_address !== want.load_address ||
            out_data.byte_index !== want.byte_index ||
            out_data.data_byte !== want.data_byte) begin
          note_error("result mismatch", want, out_data);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hex_record_parser_test: done, errors");
      $finish;
    end
  end

  initial begin
    hrp_pkg::in_t b;
    logic [7:0]   c;
    logic [7:0]   len;
    logic [7:0]   a_hi;
    logic [7:0]   a_lo;
    logic [7:0]   sum;
    logic [7:0]   skew;
    logic [7:0]   d;
    int unsigned  k;
    int unsigned  p;
    int unsigned  pick;
    bit           long_done;
    bit           pressure_done;
    bit           spoil;

    long_done     = 1'b0;
    pressure_done = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Bad starts in idle, including the end-of-file mark.
    add_row(8'h00, 1'b1, 1'b1, status_beat(hrp_pkg::ST_BAD_START, 8'h00, 16'h0000));
    add_row(hrp_pkg::CH_SUB, 1'b0, 1'b1, status_beat(hrp_pkg::ST_BAD_START, 8'h00, 16'h0000));
    // Comment that runs into the end of input.
    add_row(hrp_pkg::CH_SEMI, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, status_beat(hrp_pkg::ST_ENDED, 8'h00, 16'h0000));
    // Zero count: end-of-file line of '0', CR and LF.
    add_row(hrp_pkg::CH_COLON, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_ZERO, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_ZERO, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_ZERO, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_CR, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_LF, 1'b0, 1'b1, status_beat(hrp_pkg::ST_EOF, 8'h00, 16'h0000));
    // One byte at the top address, then a wrong checksum.
    add_row(hrp_pkg::CH_COLON, 1'b0, 1'b0, '0);
    add_row(hex_char(4'h0), 1'b0, 1'b0, '0);
    add_row(hex_char(4'h1), 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_F, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_F, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_F, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_F, 1'b0, 1'b0, '0);
    add_row(hex_char(4'h0), 1'b0, 1'b0, '0);
    add_row(hex_char(4'h0), 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_F, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_F, 1'b0, 1'b0, '0);
    add_row(hex_char(4'h0), 1'b0, 1'b0, '0);
    add_row(hex_char(4'h3), 1'b0, 1'b1,
            status_beat(hrp_pkg::ST_CHECKSUM, 8'h01, 16'hFFFF));
    // A non-hex digit, then the end-of-file mark inside a pair.
    add_row(hrp_pkg::CH_COLON, 1'b0, 1'b0, '0);
    add_row(CH_G, 1'b0, 1'b1, status_beat(hrp_pkg::ST_BAD_DIGIT, 8'h00, 16'h0000));
    add_row(hrp_pkg::CH_COLON, 1'b0, 1'b0, '0);
    add_row(hrp_pkg::CH_SUB, 1'b0, 1'b1, status_beat(hrp_pkg::ST_EOF, 8'h00, 16'h0000));

    for (k = 0; k < row_beat.size(); k++) begin
      send_beat(row_beat[k], row_typed[k], row_want[k]);
    end

    // Random text: mostly well-formed records, some spoiled, some stray noise.
    while (text_beats < RANDOM_BEATS) begin
      if (text_beats >= 2 * RANDOM_BEATS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (!pressure_done) begin
          hold_left     = HOLD_CYCLES;
          pressure_done = 1'b1;
        end
      end else if (text_beats >= RANDOM_BEATS / 3) begin
        tx_idle_pct = 69;
        rx_idle_pct = 24;
      end

      pick  = $urandom_range(99);
      spoil = 1'b0;
      if (pick >= 90) begin
        // Stray characters, sometimes with the end of input.
        repeat ($urandom_range(3, 1)) begin
          queue_beat(8'($urandom_range(255)), ($urandom_range(3) == 0));
        end
      end else begin
        // Optional comment ahead of the record.
        if ($urandom_range(99) < 20) begin
          queue_beat(hrp_pkg::CH_SEMI, 1'b0);
          repeat ($urandom_range(4)) begin
            c = 8'($urandom_range(255));
            if (c == hrp_pkg::CH_COLON) begin
              c = hrp_pkg::CH_SEMI;
            end
            hex_text.push_back(mk_beat(c, 1'b0));
          end
        end
        colon_at = hex_text.size();
        queue_beat(hrp_pkg::CH_COLON, 1'b0);

        if (pick < 72) begin
          // Data record; the first one is as long as the count allows.
          if (!long_done) begin
            len       = 8'hFF;
            long_done = 1'b1;
          end else begin
            k = $urandom_range(99);
            if (k < 75) begin
              len = 8'($urandom_range(4, 1));
            end else if (k < 95) begin
              len = 8'($urandom_range(16, 5));
            end else begin
              len = 8'($urandom_range(40, 17));
            end
            spoil = ($urandom_range(99) < 30);
          end
          a_hi = 8'($urandom_range(255));
          a_lo = 8'($urandom_range(255));
          sum  = len + a_hi + a_lo;
          queue_byte(len);
          queue_byte(a_hi);
          queue_byte(a_lo);
          queue_byte(8'($urandom_range(255)));
          for (k = 0; k < len; k++) begin
            d   = 8'($urandom_range(255));
            sum = sum + d;
            queue_byte(d);
          end
          skew = ($urandom_range(99) < 8) ? 8'($urandom_range(255, 1)) : 8'd0;
          sum  = ~sum + 8'd1 + skew;
          queue_byte(sum);
          queue_beat(hrp_pkg::CH_CR, 1'b0);
          queue_beat(hrp_pkg::CH_LF, 1'b0);
        end else begin
          // End-of-file line; the common full form fails on its type digits.
          queue_byte(8'h00);
          if ($urandom_range(3) == 0) begin
            queue_byte(8'h00);
            queue_byte(8'h00);
            queue_byte(8'h01);
            queue_byte(8'hFF);
            queue_beat(hrp_pkg::CH_CR, 1'b0);
          end else begin
            repeat ($urandom_range(3)) begin
              queue_beat(($urandom_range(1) == 0) ? hrp_pkg::CH_ZERO : hrp_pkg::CH_CR, 1'b0);
            end
          end
          queue_beat(hrp_pkg::CH_LF, 1'b0);
          spoil = ($urandom_range(99) < 20);
        end

        // Spoil one character after the start and drop the rest of the record.
        if (spoil) begin
          p = $urandom_range(hex_text.size() - 1, colon_at + 1);
          case ($urandom_range(3))
            0: hex_text[p] = mk_beat(8'($urandom_range(255)), 1'b0);
            1: hex_text[p] = mk_beat(hrp_pkg::CH_SUB, 1'b0);
            2: hex_text[p] = mk_beat(8'($urandom_range(255)), 1'b1);
            default: hex_text[p] = mk_beat(CH_LOWER_A + 8'($urandom_range(5)), 1'b0);
          endcase
          while (hex_text.size() > p + 1) begin
            void'(hex_text.pop_back());
            text_beats--;
          end
        end
      end

      while (hex_text.size() != 0) begin
        b = hex_text.pop_front();
        send_beat(b, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every booked result, then for DRAIN_CYCLES more.
    while (parsed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("hex_record_parser_test: done, clean");
    end else begin
      $display("hex_record_parser_test: done, errors");
    end
    $finish;
  end

endmodule
